// File: sv/fgn_pkg.sv
`timescale 1ns / 1ps

package fgn_pkg;

  // Block configuration.
  localparam int OCTAVE_COUNT     = 8;
  localparam int ANGLE_TABLE_BITS = 10;

  // Field and register widths.
  localparam int COORD_W = 24;
  localparam int CFG_W   = 16;
  localparam int AMP_W   = 16;
  localparam int OUT_W   = 19;
  localparam int ADDR_W  = 8;

  // Configuration register indexes.
  localparam logic [ADDR_W-1:0] CFG_BASE_FREQ = 8'd0;
  localparam logic [ADDR_W-1:0] CFG_BASE_AMP  = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] FREQ_RESET = 16'd256;
  localparam logic [AMP_W-1:0] AMP_RESET  = 16'd32768;

  // Per-octave frequency grows by one bit per octave.
  localparam int FREQ_W = CFG_W + OCTAVE_COUNT - 1;
  // Scaled coordinate, Q27.20.
  localparam int PX_W   = COORD_W + FREQ_W;
  localparam int FRAC_W = 20;

  // Lattice hash multipliers.
  localparam logic [31:0] HASH_A = 32'd3284157443;
  localparam logic [31:0] HASH_B = 32'd1911520717;
  localparam logic [31:0] HASH_C = 32'd2048419325;

  // Octave value, amplitude product and summation widths.
  localparam int VAL_W   = 18;
  localparam int PROD_W  = VAL_W + AMP_W + 1;
  localparam int SUM_LVL = $clog2(OCTAVE_COUNT);
  localparam int SUM_W   = PROD_W + OCTAVE_COUNT - 1 + SUM_LVL;
  localparam int OUT_SHIFT = 15 + OCTAVE_COUNT - 1;
  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  // Register stages inside one octave lane.
  localparam int LANE_LAT = 12;

  typedef logic signed [SUM_W-1:0] term_t;

  // Quarter-wave sine table.
  localparam int QB     = ANGLE_TABLE_BITS - 2;
  localparam int QTAB_N = 1 << QB;
  localparam logic [ANGLE_TABLE_BITS-1:0] QUARTER_TURN = ANGLE_TABLE_BITS'(QTAB_N);

  typedef logic [16:0] qsin_tab_t [QTAB_N];

  // Fifth-order odd polynomial over a quarter turn, products truncated by 15 bits.
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] inner;
    logic [63:0] mid;
    for (int k = 0; k < QTAB_N; k++) begin
      t     = 64'(k) << (17 - ANGLE_TABLE_BITS);
      t2    = (t * t) >> 15;
      inner = 64'd21024 - ((t2 * 64'd2320) >> 15);
      mid   = 64'd51472 - ((t2 * inner) >> 15);
      tab[k] = 17'((t * mid) >> 15);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  // Q2.15 sine of a full-turn angle code, folded by quadrant.
  function automatic logic signed [17:0] sin_q15(input logic [ANGLE_TABLE_BITS-1:0] idx);
    logic [1:0]  quad;
    logic [QB:0] k;
    logic [16:0] mag;
    quad = idx[ANGLE_TABLE_BITS-1 -: 2];
    k    = {1'b0, idx[QB-1:0]};
    if (quad[0]) begin
      k = (QB+1)'(QTAB_N) - k;
    end
    if (k[QB]) begin
      mag = 17'd32768;
    end else begin
      mag = QSIN_TAB[k[QB-1:0]];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Swap the 16-bit halves of a word.
  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

// File: sv/fgn_octave.sv
`timescale 1ns / 1ps

module fgn_octave (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [fgn_pkg::COORD_W-1:0]            x_i,
  input  logic [fgn_pkg::COORD_W-1:0]            y_i,
  input  logic [fgn_pkg::FREQ_W-1:0]             freq_i,
  input  logic [fgn_pkg::AMP_W-1:0]              amp_i,
  output logic signed [fgn_pkg::PROD_W-1:0]      prod_o
);

  localparam int ATB = fgn_pkg::ANGLE_TABLE_BITS;

  // Stage 1: scale coordinates by the octave frequency.
  logic [fgn_pkg::PX_W-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= fgn_pkg::PX_W'(x_i) * fgn_pkg::PX_W'(freq_i);
      py_q <= fgn_pkg::PX_W'(y_i) * fgn_pkg::PX_W'(freq_i);
    end
  end

  // Stage 2: cell corners, first hash multiply, fraction squares.
  logic [31:0] cx [2];
  logic [31:0] cy [2];
  logic [15:0] fx, fy;
  logic [31:0] sqx, sqy;
  logic [31:0] ha_q [2];
  logic [31:0] cy2_q [2];
  logic [15:0] fx2_q, fy2_q, sqx2_q, sqy2_q;

  always_comb begin
    cx[0] = 32'(px_q >> fgn_pkg::FRAC_W);
    cy[0] = 32'(py_q >> fgn_pkg::FRAC_W);
    cx[1] = cx[0] + 32'd1;
    cy[1] = cy[0] + 32'd1;
    fx    = px_q[fgn_pkg::FRAC_W-1 -: 16];
    fy    = py_q[fgn_pkg::FRAC_W-1 -: 16];
    sqx   = 32'(fx) * 32'(fx);
    sqy   = 32'(fy) * 32'(fy);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 2; i++) begin
        ha_q[i]  <= cx[i] * fgn_pkg::HASH_A;
        cy2_q[i] <= cy[i];
      end
      fx2_q  <= fx;
      fy2_q  <= fy;
      sqx2_q <= sqx[31:16];
      sqy2_q <= sqy[31:16];
    end
  end

  // Stage 3: second hash multiply per corner, smoothstep weights.
  logic [31:0] hb [4];
  logic [17:0] tx, ty;
  logic [33:0] wpx, wpy;
  logic [31:0] hb_q [4];
  logic [31:0] ha3_q [2];
  logic [15:0] fx3_q, fy3_q;
  logic [16:0] wx3_q, wy3_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hb[c] = (cy2_q[c[1]] ^ fgn_pkg::rot16(ha_q[c[0]])) * fgn_pkg::HASH_B;
    end
    tx  = 18'd196608 - {1'b0, fx2_q, 1'b0};
    ty  = 18'd196608 - {1'b0, fy2_q, 1'b0};
    wpx = 34'(sqx2_q) * 34'(tx);
    wpy = 34'(sqy2_q) * 34'(ty);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hb_q  <= hb;
      ha3_q <= ha_q;
      fx3_q <= fx2_q;
      fy3_q <= fy2_q;
      wx3_q <= wpx[32:16];
      wy3_q <= wpy[32:16];
    end
  end

  // Stage 4: final hash multiply per corner.
  logic [31:0] hc [4];
  logic [31:0] hc_q [4];
  logic [15:0] fx4_q, fy4_q;
  logic [16:0] wx4_q, wy4_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      hc[c] = (ha3_q[c[0]] ^ fgn_pkg::rot16(hb_q[c])) * fgn_pkg::HASH_C;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hc_q  <= hc;
      fx4_q <= fx3_q;
      fy4_q <= fy3_q;
      wx4_q <= wx3_q;
      wy4_q <= wy3_q;
    end
  end

  // Stage 5: gradient lookup from the top hash bits.
  logic [ATB-1:0] ang [4];
  logic signed [17:0] gx_q [4];
  logic signed [17:0] gy_q [4];
  logic [15:0] fx5_q, fy5_q;
  logic [16:0] wx5_q, wy5_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ang[c] = hc_q[c][31 -: ATB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        gx_q[c] <= fgn_pkg::sin_q15(ang[c]);
        gy_q[c] <= fgn_pkg::sin_q15(ang[c] + fgn_pkg::QUARTER_TURN);
      end
      fx5_q <= fx4_q;
      fy5_q <= fy4_q;
      wx5_q <= wx4_q;
      wy5_q <= wy4_q;
    end
  end

  // Stage 6: offset times gradient, per corner.
  logic signed [17:0] dx [4];
  logic signed [17:0] dy [4];
  logic signed [35:0] pdx_q [4];
  logic signed [35:0] pdy_q [4];
  logic [16:0] wx6_q, wy6_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dx[c] = $signed({2'b00, fx5_q}) - (c[0] ? 18'sd65536 : 18'sd0);
      dy[c] = $signed({2'b00, fy5_q}) - (c[1] ? 18'sd65536 : 18'sd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        pdx_q[c] <= 36'(dx[c]) * 36'(gx_q[c]);
        pdy_q[c] <= 36'(dy[c]) * 36'(gy_q[c]);
      end
      wx6_q <= wx5_q;
      wy6_q <= wy5_q;
    end
  end

  // Stage 7: dot products back to Q15.
  logic signed [36:0] dsum [4];
  logic signed [17:0] dot_q [4];
  logic [16:0] wx7_q, wy7_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dsum[c] = 37'(pdx_q[c]) + 37'(pdy_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        dot_q[c] <= 18'(dsum[c] >>> 16);
      end
      wx7_q <= wx6_q;
      wy7_q <= wy6_q;
    end
  end

  // Stage 8: blend products along x for the top and bottom edges.
  logic signed [36:0] mt, mb;
  logic signed [36:0] mt_q, mb_q;
  logic signed [17:0] t0_q, b0_q;
  logic [16:0] wy8_q;

  always_comb begin
    mt = (37'(dot_q[1]) - 37'(dot_q[0])) * 37'($signed({1'b0, wx7_q}));
    mb = (37'(dot_q[3]) - 37'(dot_q[2])) * 37'($signed({1'b0, wx7_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mt_q  <= mt;
      mb_q  <= mb;
      t0_q  <= dot_q[0];
      b0_q  <= dot_q[2];
      wy8_q <= wy7_q;
    end
  end

  // Stage 9: finish the x blends.
  logic signed [17:0] top_q, bot_q;
  logic [16:0] wy9_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top_q <= 18'(t0_q + (mt_q >>> 16));
      bot_q <= 18'(b0_q + (mb_q >>> 16));
      wy9_q <= wy8_q;
    end
  end

  // Stage 10: blend product along y.
  logic signed [36:0] mv;
  logic signed [36:0] mv_q;
  logic signed [17:0] top10_q;

  always_comb begin
    mv = (37'(bot_q) - 37'(top_q)) * 37'($signed({1'b0, wy9_q}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mv_q    <= mv;
      top10_q <= top_q;
    end
  end

  // Stage 11: octave noise value.
  logic signed [fgn_pkg::VAL_W-1:0] v_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= fgn_pkg::VAL_W'(top10_q + (mv_q >>> 16));
    end
  end

  // Stage 12: weight by the base amplitude.
  logic signed [fgn_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= fgn_pkg::PROD_W'(v_q) * fgn_pkg::PROD_W'($signed({1'b0, amp_i}));
    end
  end

  assign prod_o = prod_q;

endmodule

// File: sv/fgn_sum.sv
`timescale 1ns / 1ps

module fgn_sum (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  fgn_pkg::term_t                    terms_i [fgn_pkg::OCTAVE_COUNT],
  output logic signed [fgn_pkg::OUT_W-1:0]  noise_o
);

  localparam int LVL = fgn_pkg::SUM_LVL;
  localparam int NP  = 1 << LVL;
  localparam int OC  = fgn_pkg::OCTAVE_COUNT;
  localparam fgn_pkg::term_t SAT_HI = fgn_pkg::SUM_W'(fgn_pkg::OUT_MAX);
  localparam fgn_pkg::term_t SAT_LO = fgn_pkg::SUM_W'(fgn_pkg::OUT_MIN);

  // Registered adder tree: level 0 captures the terms, each level halves the count.
  fgn_pkg::term_t tree_q [LVL+1][NP];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NP; k++) begin
        tree_q[0][k] <= (k < OC) ? terms_i[k % OC] : '0;
      end
      for (int l = 0; l < LVL; l++) begin
        for (int k = 0; k < NP; k++) begin
          if (k < (NP >> (l + 1))) begin
            tree_q[l+1][k] <= tree_q[l][(2 * k) & (NP - 1)]
                            + tree_q[l][(2 * k + 1) & (NP - 1)];
          end else begin
            tree_q[l+1][k] <= '0;
          end
        end
      end
    end
  end

  // Scale back to Q3.15 and saturate.
  fgn_pkg::term_t scaled;
  logic signed [fgn_pkg::OUT_W-1:0] res_d, res_q;

  always_comb begin
    scaled = tree_q[LVL][0] >>> fgn_pkg::OUT_SHIFT;
    if (scaled > SAT_HI) begin
      res_d = fgn_pkg::OUT_W'(fgn_pkg::OUT_MAX);
    end else if (scaled < SAT_LO) begin
      res_d = fgn_pkg::OUT_W'(fgn_pkg::OUT_MIN);
    end else begin
      res_d = fgn_pkg::OUT_W'(scaled);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign noise_o = res_q;

endmodule

// File: sv/fractal_gradient_noise_2d.sv
`timescale 1ns / 1ps

// Fractal 2D gradient noise: each beat carries a Q12.12 point and returns the saturated
// sum of eight octaves of gradient noise as a signed Q3.15 value. The block accepts one
// beat per clock and returns one result per clock while results are taken; each result
// passes through the twelve-stage octave lanes, which run side by side, and then the
// registered adder tree. When the result side stalls, the whole pipeline holds. Write the
// frequency and amplitude registers only while no beat is in flight.
module fractal_gradient_noise_2d (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input beat.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,   // [23:0] x_coord, [47:24] y_coord
  // Result beat.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,   // [18:0] noise_value
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fgn_pkg::ADDR_W-1:0]     cfg_addr_i,
  input  logic [fgn_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int OC    = fgn_pkg::OCTAVE_COUNT;
  localparam int DEPTH = fgn_pkg::LANE_LAT + fgn_pkg::SUM_LVL + 2;

  // Configuration registers.
  logic [fgn_pkg::CFG_W-1:0] freq_q;
  logic [fgn_pkg::AMP_W-1:0] amp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= fgn_pkg::FREQ_RESET;
      amp_q  <= fgn_pkg::AMP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        fgn_pkg::CFG_BASE_FREQ: freq_q <= cfg_data_i;
        fgn_pkg::CFG_BASE_AMP:  amp_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the output register holds an untaken result.
  logic en;
  logic [DEPTH-1:0] vld_q;

  assign en            = !vld_q[DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // One lane per octave, each with its own frequency.
  logic signed [fgn_pkg::PROD_W-1:0] prod [OC];
  fgn_pkg::term_t terms [OC];

  for (genvar i = 0; i < OC; i++) begin : g_oct
    fgn_octave u_oct (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (s_axis_tdata[23:0]),
      .y_i    (s_axis_tdata[47:24]),
      .freq_i (fgn_pkg::FREQ_W'(freq_q) << i),
      .amp_i  (amp_q),
      .prod_o (prod[i])
    );
    // Octave weight 2^(OC-1-i) relative to the last octave.
    assign terms[i] = fgn_pkg::SUM_W'(prod[i]) <<< (OC - 1 - i);
  end

  // Octave sum and output register.
  logic signed [fgn_pkg::OUT_W-1:0] noise;

  fgn_sum u_sum (
    .clk_i   (clk_i),
    .en_i    (en),
    .terms_i (terms),
    .noise_o (noise)
  );

  assign m_axis_tvalid = vld_q[DEPTH-1];
  assign m_axis_tdata  = {5'b0, noise};

endmodule
